### hdl/i2cms_pkg.sv
`default_nettype none

package i2cms_pkg;

   // command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_EVENT = 1'b1;

   // bus actions
   localparam logic [2:0] ACT_NONE      = 3'd0;
   localparam logic [2:0] ACT_ADDR_WR   = 3'd1;
   localparam logic [2:0] ACT_ADDR_RD   = 3'd2;
   localparam logic [2:0] ACT_DATA      = 3'd3;
   localparam logic [2:0] ACT_STOP      = 3'd4;
   localparam logic [2:0] ACT_ACK       = 3'd5;
   localparam logic [2:0] ACT_NACK_STOP = 3'd6;

   // status codes
   localparam logic [2:0] ST_NONE   = 3'd0;
   localparam logic [2:0] ST_DONE   = 3'd1;
   localparam logic [2:0] ST_ARB    = 3'd2;
   localparam logic [2:0] ST_BUSERR = 3'd3;
   localparam logic [2:0] ST_NACK   = 3'd4;
   localparam logic [2:0] ST_UNEXP  = 3'd5;

   // R/W bit handling on the address byte
   localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
   localparam logic [7:0] ADDR_RD_BIT  = 8'h01;

   typedef struct packed {
      logic       command;
      logic [6:0] target_address;
      logic [7:0] write_count;
      logic [7:0] read_count;
      logic [7:0] tx_byte;
      logic       arb_lost;
      logic       bus_error;
      logic       write_done;
      logic       nack_seen;
      logic       read_done;
      logic [7:0] bus_data;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] out_byte;
      logic       read_valid;
      logic [7:0] read_byte;
      logic [2:0] status;
      logic       ready_res;
   } rsp_type;

   typedef struct packed {
      logic [7:0] tx_remaining;
      logic [7:0] rx_remaining;
      logic [7:0] address_byte;
      logic       idle;
      logic [2:0] last_status;
   } state_type;

endpackage

`default_nettype wire

### hdl/i2cms_step.sv
`default_nettype none

// Next-state and result decode for one transaction.
module i2cms_step (
   input  wire i2cms_pkg::state_type state_cur,
   input  wire i2cms_pkg::req_type   req,
   output i2cms_pkg::state_type      state_nxt,
   output i2cms_pkg::rsp_type        rsp
);

   logic [7:0] addr_new;
   logic [7:0] rx_dec;

   assign addr_new = {req.target_address, 1'b0};
   assign rx_dec   = state_cur.rx_remaining - 8'd1;

   always_comb begin
      state_nxt      = state_cur;
      rsp.action     = i2cms_pkg::ACT_NONE;
      rsp.out_byte   = 8'd0;
      rsp.read_valid = 1'b0;
      rsp.read_byte  = 8'd0;

      if (state_cur.idle) begin
         if (req.command == i2cms_pkg::CMD_START) begin
            state_nxt.address_byte = addr_new;
            state_nxt.tx_remaining = req.write_count;
            state_nxt.rx_remaining = req.read_count;
            if (req.write_count != 8'd0) begin
               state_nxt.idle = 1'b0;
               rsp.action     = i2cms_pkg::ACT_ADDR_WR;
               rsp.out_byte   = addr_new & i2cms_pkg::ADDR_WR_MASK;
            end else if (req.read_count != 8'd0) begin
               state_nxt.idle = 1'b0;
               rsp.action     = i2cms_pkg::ACT_ADDR_RD;
               rsp.out_byte   = addr_new | i2cms_pkg::ADDR_RD_BIT;
            end
         end
      end else if (req.command == i2cms_pkg::CMD_EVENT) begin
         priority if (req.arb_lost) begin
            state_nxt.last_status = i2cms_pkg::ST_ARB;
            state_nxt.idle        = 1'b1;
         end else if (req.bus_error) begin
            state_nxt.last_status = i2cms_pkg::ST_BUSERR;
            state_nxt.idle        = 1'b1;
         end else if (req.write_done) begin
            priority if (req.nack_seen) begin
               rsp.action            = i2cms_pkg::ACT_STOP;
               state_nxt.last_status = i2cms_pkg::ST_NACK;
               state_nxt.idle        = 1'b1;
            end else if (state_cur.tx_remaining != 8'd0) begin
               rsp.action             = i2cms_pkg::ACT_DATA;
               rsp.out_byte           = req.tx_byte;
               state_nxt.tx_remaining = state_cur.tx_remaining - 8'd1;
            end else if (state_cur.rx_remaining != 8'd0) begin
               // repeated start into the read phase
               rsp.action   = i2cms_pkg::ACT_ADDR_RD;
               rsp.out_byte = state_cur.address_byte | i2cms_pkg::ADDR_RD_BIT;
            end else begin
               rsp.action            = i2cms_pkg::ACT_STOP;
               state_nxt.last_status = i2cms_pkg::ST_DONE;
               state_nxt.idle        = 1'b1;
            end
         end else if (req.read_done) begin
            if (state_cur.rx_remaining != 8'd0) begin
               rsp.read_valid         = 1'b1;
               rsp.read_byte          = req.bus_data;
               state_nxt.rx_remaining = rx_dec;
               if (rx_dec == 8'd0) begin
                  rsp.action            = i2cms_pkg::ACT_NACK_STOP;
                  state_nxt.last_status = i2cms_pkg::ST_DONE;
                  state_nxt.idle        = 1'b1;
               end else begin
                  rsp.action = i2cms_pkg::ACT_ACK;
               end
            end else begin
               rsp.action            = i2cms_pkg::ACT_NACK_STOP;
               state_nxt.last_status = i2cms_pkg::ST_DONE;
               state_nxt.idle        = 1'b1;
            end
         end else begin
            state_nxt.last_status = i2cms_pkg::ST_UNEXP;
            state_nxt.idle        = 1'b1;
         end
      end

      rsp.status    = state_nxt.last_status;
      rsp.ready_res = state_nxt.idle;
   end

endmodule

`default_nettype wire

### hdl/i2c_master_transaction_sequencer.sv
// I2C master write-then-read byte sequencer.
// req channel: one transaction is either a start command (address, write
// and read counts) or a bus event (flags, tx_byte, bus_data). Accepted when
// req_valid is high and req_stall low.
// rsp channel: exactly one result per request: bus action, byte to drive,
// captured read byte, sticky status and the idle flag after the step.
// Pipeline: input register, then decode into the result register. Throughput:
// one transaction per cycle while rsp_stall does not hold the result
// register; the sequencer state updates as each transaction enters the
// result register, so the next one sees it without bubbles.
// rsp_stall: the result register holds; the input register keeps one more
// transaction and req_stall rises only when both are full.
// Reset (synchronous, active high): both registers empty, counters and
// address cleared, idle set, status none.
`default_nettype none

module i2c_master_transaction_sequencer (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire i2cms_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output i2cms_pkg::rsp_type   rsp_payload
);

   // input register
   logic                 s1_valid_ff, s1_valid_in;
   i2cms_pkg::req_type   s1_req_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   i2cms_pkg::rsp_type   rsp_ff;

   // sequencer state
   i2cms_pkg::state_type state_ff, state_in;
   i2cms_pkg::rsp_type   rsp_in;

   logic s2_open;   // result register can take a transaction this cycle
   logic s2_load;   // input register moves into result register
   logic s1_load;

   assign s2_open = !rsp_valid_ff || !rsp_stall;
   assign s2_load = s1_valid_ff && s2_open;
   assign req_stall = s1_valid_ff && !s2_open;
   assign s1_load = req_valid && !req_stall;

   assign s1_valid_in  = s1_load || (s1_valid_ff && !s2_load);
   assign rsp_valid_in = s2_load || (rsp_valid_ff && rsp_stall);

   i2cms_step u_step (
      .state_cur (state_ff),
      .req       (s1_req_ff),
      .state_nxt (state_in),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         state_ff.tx_remaining <= 8'd0;
         state_ff.rx_remaining <= 8'd0;
         state_ff.address_byte <= 8'd0;
         state_ff.idle         <= 1'b1;
         state_ff.last_status  <= i2cms_pkg::ST_NONE;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s2_load) begin
            state_ff <= state_in;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_req_ff <= req_payload;
      end
      if (s2_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // result idle flag matches the sequencer state after the step
   a_idle_track : assert property (@(posedge clock) disable iff (reset)
      s2_load |=> (rsp_ff.ready_res == state_ff.idle))
      else $error("result idle flag does not match sequencer state");

   // captured bytes come only with an ACK or NACK-stop
   a_read_action : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.read_valid) |->
         (rsp_ff.action == i2cms_pkg::ACT_ACK ||
          rsp_ff.action == i2cms_pkg::ACT_NACK_STOP))
      else $error("read byte without read action");

   // continuing actions leave the sequencer busy
   a_busy_cont : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.action == i2cms_pkg::ACT_ADDR_WR ||
                        rsp_ff.action == i2cms_pkg::ACT_ADDR_RD ||
                        rsp_ff.action == i2cms_pkg::ACT_DATA ||
                        rsp_ff.action == i2cms_pkg::ACT_ACK)) |-> !rsp_ff.ready_res)
      else $error("continuing action reported idle");

   // back-pressure only when the input register holds a transaction
   a_stall_src : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

endmodule

`default_nettype wire

### test/testbench.sv
module testbench;

   // event flag sets, packed as {arb_lost, bus_error, write_done, nack_seen, read_done}
   localparam logic [4:0] EV_NONE    = 5'b00000;
   localparam logic [4:0] EV_ALL     = 5'b11111;
   localparam logic [4:0] EV_ARB     = 5'b10000;
   localparam logic [4:0] EV_BERR_WR = 5'b01101;
   localparam logic [4:0] EV_WR      = 5'b00100;
   localparam logic [4:0] EV_WR_NACK = 5'b00110;
   localparam logic [4:0] EV_RD      = 5'b00001;

   localparam int RANDOM_WORK = 1900;   // non-ignored transactions in the random phase

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   i2cms_pkg::req_type req_payload;
   logic               rsp_valid;
   logic               rsp_stall;
   i2cms_pkg::rsp_type rsp_payload;

   // sequencer state as predicted, and bus responses still owed by the block
   i2cms_pkg::state_type ctrl_state;
   i2cms_pkg::rsp_type   awaited_rsp[$];
   i2cms_pkg::rsp_type   last_predicted;
   i2cms_pkg::rsp_type   oldest_rsp;
   logic      read_addr_sent;   // repeated-start read address already issued
   logic      no_idle;          // both sides run back to back while set
   int        mismatch_count;

   i2c_master_transaction_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard limit on simulation time
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   // Predicted response for one transaction; advances ctrl_state.
   function automatic i2cms_pkg::rsp_type sequencer_step(input i2cms_pkg::req_type t);
      i2cms_pkg::rsp_type r;
      r = '0;
      if (ctrl_state.idle) begin
         // events while idle are dropped; a start always latches its operands
         if (t.command == i2cms_pkg::CMD_START) begin
            ctrl_state.address_byte = {t.target_address, 1'b0};
            ctrl_state.tx_remaining = t.write_count;
            ctrl_state.rx_remaining = t.read_count;
            if (t.write_count != 8'd0) begin
               ctrl_state.idle = 1'b0;
               r.action        = i2cms_pkg::ACT_ADDR_WR;
               r.out_byte      = ctrl_state.address_byte & i2cms_pkg::ADDR_WR_MASK;
            end else if (t.read_count != 8'd0) begin
               ctrl_state.idle = 1'b0;
               r.action        = i2cms_pkg::ACT_ADDR_RD;
               r.out_byte      = ctrl_state.address_byte | i2cms_pkg::ADDR_RD_BIT;
            end
         end
      end else if (t.command == i2cms_pkg::CMD_EVENT) begin
         // fixed priority: arbitration, bus error, write, read, else unexpected
         if (t.arb_lost) begin
            ctrl_state.last_status = i2cms_pkg::ST_ARB;
            ctrl_state.idle        = 1'b1;
         end else if (t.bus_error) begin
            ctrl_state.last_status = i2cms_pkg::ST_BUSERR;
            ctrl_state.idle        = 1'b1;
         end else if (t.write_done) begin
            if (t.nack_seen) begin
               r.action               = i2cms_pkg::ACT_STOP;
               ctrl_state.last_status = i2cms_pkg::ST_NACK;
               ctrl_state.idle        = 1'b1;
            end else if (ctrl_state.tx_remaining != 8'd0) begin
               r.action                = i2cms_pkg::ACT_DATA;
               r.out_byte              = t.tx_byte;
               ctrl_state.tx_remaining = ctrl_state.tx_remaining - 8'd1;
            end else if (ctrl_state.rx_remaining != 8'd0) begin
               r.action   = i2cms_pkg::ACT_ADDR_RD;
               r.out_byte = ctrl_state.address_byte | i2cms_pkg::ADDR_RD_BIT;
            end else begin
               r.action               = i2cms_pkg::ACT_STOP;
               ctrl_state.last_status = i2cms_pkg::ST_DONE;
               ctrl_state.idle        = 1'b1;
            end
         end else if (t.read_done) begin
            // capture only while bytes are owed; the last one gets the NACK
            if (ctrl_state.rx_remaining != 8'd0) begin
               r.read_valid            = 1'b1;
               r.read_byte             = t.bus_data;
               ctrl_state.rx_remaining = ctrl_state.rx_remaining - 8'd1;
            end
            if (ctrl_state.rx_remaining == 8'd0) begin
               r.action               = i2cms_pkg::ACT_NACK_STOP;
               ctrl_state.last_status = i2cms_pkg::ST_DONE;
               ctrl_state.idle        = 1'b1;
            end else begin
               r.action = i2cms_pkg::ACT_ACK;
            end
         end else begin
            ctrl_state.last_status = i2cms_pkg::ST_UNEXP;
            ctrl_state.idle        = 1'b1;
         end
      end
      r.status    = ctrl_state.last_status;
      r.ready_res = ctrl_state.idle;
      return r;
   endfunction

   // every field random; callers overwrite what matters
   function automatic i2cms_pkg::req_type random_fields();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[$bits(i2cms_pkg::req_type)-1:0];
   endfunction

   function automatic i2cms_pkg::req_type start_cmd(input logic [6:0] addr,
                                                    input logic [7:0] wcnt,
                                                    input logic [7:0] rcnt);
      i2cms_pkg::req_type t;
      t                = random_fields();
      t.command        = i2cms_pkg::CMD_START;
      t.target_address = addr;
      t.write_count    = wcnt;
      t.read_count     = rcnt;
      return t;
   endfunction

   function automatic i2cms_pkg::req_type bus_event(input logic [4:0] flags,
                                                    input logic [7:0] txb,
                                                    input logic [7:0] rxd);
      i2cms_pkg::req_type t;
      t         = random_fields();
      t.command = i2cms_pkg::CMD_EVENT;
      {t.arb_lost, t.bus_error, t.write_done, t.nack_seen, t.read_done} = flags;
      t.tx_byte  = txb;
      t.bus_data = rxd;
      return t;
   endfunction

   // Drive one transaction after a random gap, hold it until accepted, then predict.
   task automatic send_transaction(input i2cms_pkg::req_type t);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_payload = t;
      req_valid   = 1'b1;
      do @(posedge clock); while (req_stall);
      last_predicted = sequencer_step(t);
      awaited_rsp.push_back(last_predicted);
      if (last_predicted.action == i2cms_pkg::ACT_ADDR_RD) read_addr_sent = 1'b1;
      else if (last_predicted.action == i2cms_pkg::ACT_ADDR_WR) read_addr_sent = 1'b0;
   endtask

   // Response side: random stall before each response, sometimes none at all.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 10);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall = 1'b1;
         end
         @(negedge clock);
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic report_mismatch(input string field, input logic [7:0] want,
                                  input logic [7:0] got);
      mismatch_count++;
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
   endtask

   // Response checker: each accepted response against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsp.size() == 0) begin
            mismatch_count++;
            $display("%0t: response expected none actual %p", $time, rsp_payload);
         end else begin
            oldest_rsp = awaited_rsp.pop_front();
            if (rsp_payload.action !== oldest_rsp.action)
               report_mismatch("action", 8'(oldest_rsp.action), 8'(rsp_payload.action));
            if (rsp_payload.out_byte !== oldest_rsp.out_byte)
               report_mismatch("out_byte", oldest_rsp.out_byte, rsp_payload.out_byte);
            if (rsp_payload.read_valid !== oldest_rsp.read_valid)
               report_mismatch("read_valid", 8'(oldest_rsp.read_valid),
                               8'(rsp_payload.read_valid));
            if (rsp_payload.read_byte !== oldest_rsp.read_byte)
               report_mismatch("read_byte", oldest_rsp.read_byte, rsp_payload.read_byte);
            if (rsp_payload.status !== oldest_rsp.status)
               report_mismatch("status", 8'(oldest_rsp.status), 8'(rsp_payload.status));
            if (rsp_payload.ready_res !== oldest_rsp.ready_res)
               report_mismatch("ready_res", 8'(oldest_rsp.ready_res),
                               8'(rsp_payload.ready_res));
         end
      end
   end

   // idle block: events dropped, empty start stays ready
   task automatic test_idle_behavior();
      send_transaction(bus_event(EV_ALL, 8'hFF, 8'hFF));
      send_transaction(bus_event(EV_NONE, 8'h00, 8'h00));
      send_transaction(start_cmd(7'h55, 8'd0, 8'd0));
   endtask

   task automatic test_write_only();
      send_transaction(start_cmd(7'h7F, 8'd2, 8'd0));
      send_transaction(bus_event(EV_WR, 8'hFF, 8'h00));
      send_transaction(bus_event(EV_WR, 8'h00, 8'hFF));
      send_transaction(bus_event(EV_WR, 8'h5A, 8'h00));   // stop, done
   endtask

   // write, repeated start, two reads with ACK then NACK
   task automatic test_write_then_read();
      send_transaction(start_cmd(7'h00, 8'd1, 8'd2));
      send_transaction(bus_event(EV_WR, 8'hA5, 8'h00));
      send_transaction(bus_event(EV_WR, 8'h00, 8'h00));
      send_transaction(bus_event(EV_RD, 8'h00, 8'hFF));
      send_transaction(bus_event(EV_RD, 8'hFF, 8'h00));
   endtask

   task automatic test_read_only();
      send_transaction(start_cmd(7'h2A, 8'd0, 8'd1));
      send_transaction(bus_event(EV_RD, 8'h00, 8'h3C));
   endtask

   task automatic test_nack_stop();
      send_transaction(start_cmd(7'h11, 8'd3, 8'd0));
      send_transaction(bus_event(EV_WR_NACK, 8'h77, 8'h00));
   endtask

   // arbitration lost beats everything, bus error beats write/read, no flag is unexpected
   task automatic test_fault_events();
      send_transaction(start_cmd(7'h7F, 8'd255, 8'd255));
      send_transaction(bus_event(EV_ALL, 8'h12, 8'h34));
      send_transaction(start_cmd(7'h01, 8'd0, 8'd255));
      send_transaction(bus_event(EV_BERR_WR, 8'h00, 8'h00));
      send_transaction(start_cmd(7'h40, 8'd1, 8'd1));
      send_transaction(bus_event(EV_NONE, 8'h00, 8'h00));
      send_transaction(start_cmd(7'h03, 8'd1, 8'd0));
      send_transaction(bus_event(EV_ARB, 8'h00, 8'h00));
   endtask

   task automatic test_start_while_busy();
      send_transaction(start_cmd(7'h12, 8'd1, 8'd0));
      send_transaction(start_cmd(7'h34, 8'd2, 8'd2));   // dropped
      send_transaction(bus_event(EV_WR, 8'hC3, 8'h00));
      send_transaction(bus_event(EV_WR, 8'h00, 8'h00));
   endtask

   // read event when nothing is owed: NACK stop without capture
   task automatic test_read_with_nothing_owed();
      send_transaction(start_cmd(7'h66, 8'd1, 8'd0));
      send_transaction(bus_event(EV_RD, 8'h00, 8'hE7));
   endtask

   // Next random transaction, mostly what a well-behaved bus would raise next.
   function automatic i2cms_pkg::req_type next_random_item();
      i2cms_pkg::req_type t;
      t = random_fields();
      if (ctrl_state.idle) begin
         if ($urandom_range(0, 9) == 0) begin
            t.command = i2cms_pkg::CMD_EVENT;   // stray event, dropped
            return t;
         end
         t.command     = i2cms_pkg::CMD_START;
         t.write_count = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 4));
         t.read_count  = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 4));
         return t;
      end
      if ($urandom_range(0, 24) == 0) return t;   // noise: random flags or a start
      t.command   = i2cms_pkg::CMD_EVENT;
      t.arb_lost  = 1'b0;
      t.bus_error = 1'b0;
      if (ctrl_state.tx_remaining != 8'd0 || ctrl_state.rx_remaining == 8'd0
          || !read_addr_sent) begin
         t.write_done = 1'b1;
         t.nack_seen  = ($urandom_range(0, 29) == 0);
      end else begin
         t.write_done = 1'b0;
         t.read_done  = 1'b1;
      end
      return t;
   endfunction

   task automatic test_random_traffic();
      i2cms_pkg::req_type t;
      int                 useful_sent;
      useful_sent = 0;
      while (useful_sent < RANDOM_WORK) begin
         t = next_random_item();
         // dropped transactions don't count toward the total
         if (ctrl_state.idle ? (t.command == i2cms_pkg::CMD_START)
                             : (t.command == i2cms_pkg::CMD_EVENT))
            useful_sent++;
         if (ctrl_state.idle && t.command == i2cms_pkg::CMD_START)
            no_idle = ($urandom_range(0, 5) == 0);
         send_transaction(t);
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_payload    = '0;
      no_idle        = 1'b0;
      read_addr_sent = 1'b0;
      mismatch_count = 0;
      ctrl_state     = '0;
      ctrl_state.idle = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_behavior();
      test_write_only();
      test_write_then_read();
      test_read_only();
      test_nack_stop();
      test_fault_events();
      test_start_while_busy();
      test_read_with_nothing_owed();
      test_random_traffic();

      @(negedge clock);
      req_valid = 1'b0;
      no_idle   = 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      // two-stage pipe: wait on to catch any stray response
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && awaited_rsp.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
